// ===== rtl/bdg_pkg.sv =====
`default_nettype none

package bdg_pkg;

  localparam int CH_W    = 8;
  localparam int NCH     = 3;
  localparam int SUM_W   = 12;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;
  localparam int BCOL_W  = 6;
  localparam int BROW_W  = 7;
  localparam int PROD_W  = 25;
  localparam int DIV9_SHIFT = 16;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [12:0]       DIV9_MUL   = 13'd7282;
  localparam logic [SUM_W-1:0]  SUM_MAX    = 12'hFFF;
  localparam logic [CH_W-1:0]   CH_MAX     = 8'hFF;
  localparam logic [1:0]        PH_LAST    = 2'd2;
  localparam logic [COL_W-1:0]  WIDTH_RST  = 7'd39;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 8'd27;

  typedef enum logic [1:0] {
    REG_SCALE_MODE   = 2'd0,
    REG_GAMMA_ENABLE = 2'd1,
    REG_SRC_WIDTH    = 2'd2,
    REG_SRC_HEIGHT   = 2'd3
  } reg_idx_t;

  typedef logic [NCH-1:0][CH_W-1:0]  ch3_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sum3_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [1:0]        cph;
    logic [BCOL_W-1:0] bcol;
    logic [ROW_W-1:0]  row;
    logic [1:0]        rph;
    logic [BROW_W-1:0] brow;
  } pos_t;

  typedef struct packed {
    logic en;
    logic start;
    ch3_t rgb;
  } acc_req_t;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    ch3_t             color;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/bdg_pos.sv =====
`default_nettype none

module bdg_pos import bdg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [COL_W-1:0] width,
  input  logic [ROW_W-1:0] height,
  output pos_t             pos
);

  pos_t             pos_r, pos_nxt;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;

  assign col_inc = pos_r.col + 1'b1;
  assign row_inc = pos_r.row + 1'b1;
  assign pos     = pos_r;

  always_comb begin
    pos_nxt = pos_r;
    if (step) begin
      if (col_inc == '0) begin
        pos_nxt.col  = '0;
        pos_nxt.cph  = '0;
        pos_nxt.bcol = '0;
      end else if (col_inc >= width) begin
        pos_nxt.col  = '0;
        pos_nxt.cph  = '0;
        pos_nxt.bcol = '0;
        if (row_inc == '0 || row_inc >= height) begin
          pos_nxt.row  = '0;
          pos_nxt.rph  = '0;
          pos_nxt.brow = '0;
        end else begin
          pos_nxt.row = row_inc;
          if (pos_r.rph == PH_LAST) begin
            pos_nxt.rph  = '0;
            pos_nxt.brow = pos_r.brow + 1'b1;
          end else begin
            pos_nxt.rph = pos_r.rph + 1'b1;
          end
        end
      end else begin
        pos_nxt.col = col_inc;
        if (pos_r.cph == PH_LAST) begin
          pos_nxt.cph  = '0;
          pos_nxt.bcol = pos_r.bcol + 1'b1;
        end else begin
          pos_nxt.cph = pos_r.cph + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdg_accum.sv =====
`default_nettype none

module bdg_accum import bdg_pkg::*; #(
  parameter int MAX_OUT_COLS = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  acc_req_t      req,
  input  logic [AW-1:0] req_addr,
  output sum3_t         sums
);

  sum3_t                   sum_mem_r [MAX_OUT_COLS];
  logic [MAX_OUT_COLS-1:0] filled_r;
  sum3_t                   rd_r, fwd_r, old_sum, wdata;
  logic                    fwd_hit_r, rd_filled_r, en1_r, start1_r;
  logic [AW-1:0]           addr1_r;
  ch3_t                    rgb1_r;
  logic [SUM_W:0]          raw [NCH];

  always_comb begin
    if (start1_r) begin
      old_sum = '0;
    end else if (fwd_hit_r) begin
      old_sum = fwd_r;
    end else if (rd_filled_r) begin
      old_sum = rd_r;
    end else begin
      old_sum = '0;
    end
    for (int i = 0; i < NCH; i++) begin
      raw[i] = {1'b0, old_sum[i]} + {{(SUM_W + 1 - CH_W){1'b0}}, rgb1_r[i]};
      wdata[i] = raw[i][SUM_W] ? SUM_MAX : raw[i][SUM_W-1:0];
    end
  end

  assign sums = wdata;

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_r        <= sum_mem_r[req_addr];
      rd_filled_r <= filled_r[req_addr];
    end
    if (en1_r) begin
      sum_mem_r[addr1_r] <= wdata;
    end
    fwd_r    <= wdata;
    addr1_r  <= req_addr;
    start1_r <= req.start;
    rgb1_r   <= req.rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en1_r     <= 1'b0;
      fwd_hit_r <= 1'b0;
      filled_r  <= '0;
    end else begin
      en1_r     <= req.en;
      fwd_hit_r <= req.en && en1_r && (addr1_r == req_addr);
      if (en1_r) begin
        filled_r[addr1_r] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdg_gamma.sv =====
`default_nettype none

module bdg_gamma import bdg_pkg::*; (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_idx,
  input  logic [CH_W-1:0] wr_val,
  input  ch3_t            rd_addr,
  output ch3_t            rd_data
);

  logic [CH_W-1:0] lut_mem_r [NCH][256];
  ch3_t            rd_data_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      if (wr_en) begin
        lut_mem_r[i][wr_idx] <= wr_val;
      end
      rd_data_r[i] <= lut_mem_r[i][rd_addr[i]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/bdg_ofifo.sv =====
`default_nettype none

module bdg_ofifo import bdg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  output logic [FIFO_AW:0] count
);

  out_item_t          buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_downscale_gamma_pixel.sv =====
`default_nettype none

// Channel   Direction  Handshake         Payload
// in        input      in_valid/stall    in_op, in_pixel_rgb, in_gamma_index, in_gamma_value
// out       output     out_valid/stall   out_x, out_y, out_color
// cfg       input      APB write/read    paddr, pwdata, prdata
//
// One item is taken per cycle while in_stall is low; results pass s1, s2, s3 to the queue.
// The column sums sit in a registered-read memory with forwarding from the write-back stage.
// Reset clears the counters, the column valid bits, the pipeline and the output queue.
// in_stall rises once the output queue and the results in flight together hold seven items.

module box_downscale_gamma_pixel import bdg_pkg::*; #(
  parameter int MAX_OUT_COLS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [23:0]         in_pixel_rgb,
  input  logic [CH_W-1:0]     in_gamma_index,
  input  logic [CH_W-1:0]     in_gamma_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COL_W-1:0]    out_x,
  output logic [ROW_W-1:0]    out_y,
  output logic [23:0]         out_color,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  localparam int AW = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;

  logic             scale_mode_r, gamma_enable_r;
  logic [COL_W-1:0] src_width_r;
  logic [ROW_W-1:0] src_height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r   <= 1'b0;
      gamma_enable_r <= 1'b0;
      src_width_r    <= WIDTH_RST;
      src_height_r   <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE_MODE:   scale_mode_r   <= pwdata[0];
        REG_GAMMA_ENABLE: gamma_enable_r <= pwdata[0];
        REG_SRC_WIDTH:    src_width_r    <= pwdata[COL_W-1:0];
        REG_SRC_HEIGHT:   src_height_r   <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE_MODE:   prdata = {{(CFG_DW - 1){1'b0}}, scale_mode_r};
      REG_GAMMA_ENABLE: prdata = {{(CFG_DW - 1){1'b0}}, gamma_enable_r};
      REG_SRC_WIDTH:    prdata = {{(CFG_DW - COL_W){1'b0}}, src_width_r};
      REG_SRC_HEIGHT:   prdata = {{(CFG_DW - ROW_W){1'b0}}, src_height_r};
      default:          prdata = '0;
    endcase
  end

  logic             acc, pix_acc, in_range, blk_start, blk_end, emit0;
  pos_t             pos;
  logic [7:0]       bcol_ext;
  acc_req_t         req;
  logic [FIFO_AW:0] fifo_cnt;
  logic [FIFO_AW:0] inflight;

  logic             s1_emit_r, s1_gw_r, s1_scale_r;
  logic             s2_emit_r, s2_gw_r, s2_scale_r;
  logic             s3_emit_r;
  logic [COL_W-1:0] s1_x_r, s2_x_r, s3_x_r;
  logic [ROW_W-1:0] s1_y_r, s2_y_r, s3_y_r;
  ch3_t             s1_rgb_r;
  logic [CH_W-1:0]  s1_gidx_r, s1_gval_r, s2_gidx_r, s2_gval_r;
  sum3_t            s2_ch_r, sums;
  ch3_t             avg, s3_avg_r, gamma_rd, color3;
  logic [PROD_W-1:0] prod [NCH];
  logic [8:0]       quot [NCH];
  out_item_t        push_item, pop_item;

  assign inflight = fifo_cnt + {{FIFO_AW{1'b0}}, s1_emit_r} + {{FIFO_AW{1'b0}}, s2_emit_r}
                  + {{FIFO_AW{1'b0}}, s3_emit_r};
  assign in_stall = (inflight >= (FIFO_AW + 1)'(FIFO_DEPTH - 1));
  assign acc      = in_valid && !in_stall;
  assign pix_acc  = acc && !in_op;

  bdg_pos u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (pix_acc),
    .width  (src_width_r),
    .height (src_height_r),
    .pos    (pos)
  );

  assign bcol_ext  = {{(8 - BCOL_W){1'b0}}, pos.bcol};
  assign in_range  = {1'b0, bcol_ext} < 9'(MAX_OUT_COLS);
  assign blk_start = (pos.cph == '0) && (pos.rph == '0);
  assign blk_end   = (pos.cph == PH_LAST) && (pos.rph == PH_LAST);
  assign emit0     = pix_acc && (!scale_mode_r || (in_range && blk_end));

  assign req.en    = pix_acc && scale_mode_r && in_range;
  assign req.start = blk_start;
  assign req.rgb   = in_pixel_rgb;

  bdg_accum #(
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .AW           (AW)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .req_addr (bcol_ext[AW-1:0]),
    .sums     (sums)
  );

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      prod[i] = PROD_W'(s2_ch_r[i]) * PROD_W'(DIV9_MUL);
      quot[i] = prod[i][DIV9_SHIFT+8:DIV9_SHIFT];
      if (!s2_scale_r) begin
        avg[i] = s2_ch_r[i][CH_W-1:0];
      end else if (quot[i][8]) begin
        avg[i] = CH_MAX;
      end else begin
        avg[i] = quot[i][CH_W-1:0];
      end
    end
  end

  bdg_gamma u_gamma (
    .clk     (clk),
    .wr_en   (s2_gw_r),
    .wr_idx  (s2_gidx_r),
    .wr_val  (s2_gval_r),
    .rd_addr (avg),
    .rd_data (gamma_rd)
  );

  assign color3          = gamma_enable_r ? gamma_rd : s3_avg_r;
  assign push_item.x     = s3_x_r;
  assign push_item.y     = s3_y_r;
  assign push_item.color = color3;

  always_ff @(posedge clk) begin
    s1_scale_r <= scale_mode_r;
    s1_x_r     <= scale_mode_r ? {1'b0, pos.bcol} : pos.col;
    s1_y_r     <= scale_mode_r ? {1'b0, pos.brow} : pos.row;
    s1_rgb_r   <= in_pixel_rgb;
    s1_gidx_r  <= in_gamma_index;
    s1_gval_r  <= in_gamma_value;

    s2_scale_r <= s1_scale_r;
    s2_x_r     <= s1_x_r;
    s2_y_r     <= s1_y_r;
    s2_gidx_r  <= s1_gidx_r;
    s2_gval_r  <= s1_gval_r;
    for (int i = 0; i < NCH; i++) begin
      s2_ch_r[i] <= s1_scale_r ? sums[i] : {{(SUM_W - CH_W){1'b0}}, s1_rgb_r[i]};
    end

    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    s3_avg_r <= avg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_emit_r <= 1'b0;
      s1_gw_r   <= 1'b0;
      s2_emit_r <= 1'b0;
      s2_gw_r   <= 1'b0;
      s3_emit_r <= 1'b0;
    end else begin
      s1_emit_r <= emit0;
      s1_gw_r   <= acc && in_op;
      s2_emit_r <= s1_emit_r;
      s2_gw_r   <= s1_gw_r;
      s3_emit_r <= s2_emit_r;
    end
  end

  bdg_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_emit_r),
    .push_data (push_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (pop_item),
    .count     (fifo_cnt)
  );

  assign out_x     = pop_item.x;
  assign out_y     = pop_item.y;
  assign out_color = pop_item.color;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("output queue overrun");

  a_pass_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_acc && !scale_mode_r) |-> ##3 s3_emit_r)
    else $error("pass-through pixel lost in pipeline");

  a_gw_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s2_gw_r |-> !s2_emit_r)
    else $error("gamma write item produced a result");

endmodule

`default_nettype wire
